/* design/piecewise_linear_time_profile_core_defines.svh */
// ----------------------------------------------------------------------------
// Piecewise-linear time profile core: assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_TIME_PROFILE_CORE_DEFINES_SVH
`define PIECEWISE_LINEAR_TIME_PROFILE_CORE_DEFINES_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define PLT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("plt: assertion failed");
// Check a property on every clock edge, reset included.
`define PLT_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("plt: assertion failed");
`else
`define PLT_ASSERT(lbl, clk, rst, prop)
`define PLT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* design/plt_pkg.sv */
// ----------------------------------------------------------------------------
// Piecewise-linear time profile: shared package
// Field widths, register codes, command format between front and back.
// ----------------------------------------------------------------------------
package plt_pkg;

   localparam int TIME_W      = 32;
   localparam int FLOW_W      = 32;
   localparam int FLUX_W      = 36;
   localparam int GAIN_W      = 16;
   localparam int GAIN_FRAC   = 12;
   localparam int COUNT_W     = 5;
   localparam int ENTRY_IDX_W = 4;
   localparam int FRAC_BITS   = 16;
   localparam int QUOT_W      = FRAC_BITS + 1;
   localparam int DIV_CNT_W   = 5;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam int TABLE_DEPTH_DEFAULT = 16;
   // Power of two, so the queue pointers wrap on their own.
   localparam int QUEUE_DEPTH = 2;

   localparam logic [TIME_W-1:0]  ONSET_RESET = '0;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd2;
   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd4096;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ONSET = 2'd0,
      CSR_COUNT = 2'd1,
      CSR_GAIN  = 2'd2
   } csr_index_type;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_ZERO  = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   // tval holds the breakpoint time for writes and the elapsed time for queries.
   typedef struct packed {
      op_type                 op;
      logic [ENTRY_IDX_W-1:0] idx;
      logic [TIME_W-1:0]      tval;
      logic [FLOW_W-1:0]      flow;
   } cmd_type;

endpackage

/* design/plt_channels.sv */
// ----------------------------------------------------------------------------
// Piecewise-linear time profile: channel interfaces
// Request, response and register-write channels with valid/ready.
// ----------------------------------------------------------------------------
interface plt_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 req_type;
   logic [plt_pkg::ENTRY_IDX_W-1:0]      entry_index;
   logic [plt_pkg::TIME_W-1:0]           entry_time;
   logic [plt_pkg::FLOW_W-1:0]           entry_flow;
   logic [plt_pkg::TIME_W-1:0]           query_time;

   modport source (output valid, req_type, entry_index, entry_time, entry_flow,
                   query_time, input ready);
   modport sink   (input valid, req_type, entry_index, entry_time, entry_flow,
                   query_time, output ready);
endinterface

interface plt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [plt_pkg::FLUX_W-1:0]  flux_value;
   logic                        in_window;

   modport source (output valid, flux_value, in_window, input ready);
   modport sink   (input valid, flux_value, in_window, output ready);
endinterface

interface plt_csr_if;
   logic                             valid;
   logic                             ready;
   logic [plt_pkg::CSR_INDEX_W-1:0]  index;
   logic [plt_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* design/plt_front.sv */
// ----------------------------------------------------------------------------
// Piecewise-linear time profile: front end
// Classify each request and form the elapsed time before queuing it.
// ----------------------------------------------------------------------------
module plt_front #(
   parameter int TABLE_DEPTH = plt_pkg::TABLE_DEPTH_DEFAULT
) (
   plt_req_if.sink                     req_ch,
   input  logic [plt_pkg::TIME_W-1:0]  onset_time,
   output logic                        push_valid,
   input  logic                        push_ready,
   output plt_pkg::cmd_type            push_cmd
);

   logic [31:0]                 idx_wide;
   logic                        idx_ok;
   logic                        before_onset;
   logic [plt_pkg::TIME_W-1:0]  elapsed;

   assign idx_wide     = 32'(req_ch.entry_index);
   assign idx_ok       = idx_wide < 32'(TABLE_DEPTH);
   assign before_onset = req_ch.query_time < onset_time;
   assign elapsed      = req_ch.query_time - onset_time;

   assign push_valid   = req_ch.valid;
   assign req_ch.ready = push_ready;

   always_comb begin
      push_cmd.idx  = req_ch.entry_index;
      push_cmd.flow = req_ch.entry_flow;
      if (req_ch.req_type == plt_pkg::REQ_LOAD) begin
         // Drop writes past the table, but still answer them.
         push_cmd.op   = idx_ok ? plt_pkg::OP_WRITE : plt_pkg::OP_ZERO;
         push_cmd.tval = req_ch.entry_time;
      end else begin
         push_cmd.op   = before_onset ? plt_pkg::OP_ZERO : plt_pkg::OP_QUERY;
         push_cmd.tval = elapsed;
      end
   end

endmodule

/* design/plt_cmd_queue.sv */
// ----------------------------------------------------------------------------
// Piecewise-linear time profile: command queue
// Short FIFO that decouples the front end from the sequencer.
// ----------------------------------------------------------------------------
module plt_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  plt_pkg::cmd_type  push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output plt_pkg::cmd_type  pop_cmd
);

   localparam int PTR_W = $clog2(plt_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(plt_pkg::QUEUE_DEPTH + 1);

   plt_pkg::cmd_type   slots_ff [plt_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(plt_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* design/plt_back.sv */
// ----------------------------------------------------------------------------
// Piecewise-linear time profile: back end
// Breakpoint memory, segment search, serial divide, blend, gain, response.
// ----------------------------------------------------------------------------
`include "piecewise_linear_time_profile_core_defines.svh"

module plt_back #(
   parameter int TABLE_DEPTH = plt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         pop_valid,
   output logic                         pop_ready,
   input  plt_pkg::cmd_type             pop_cmd,
   input  logic [plt_pkg::COUNT_W-1:0]  table_count,
   input  logic [plt_pkg::GAIN_W-1:0]   emission_gain,
   plt_rsp_if.source                    rsp_ch
);

   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W  = (CNT_W > plt_pkg::COUNT_W) ? CNT_W : plt_pkg::COUNT_W;
   localparam int TW     = plt_pkg::TIME_W;
   localparam int FW     = plt_pkg::FLOW_W;
   localparam int WORD_W = TW + FW;
   localparam int QW     = plt_pkg::QUOT_W;
   localparam int PROD_W = FW + 1 + QW + 1;
   localparam int GP_W   = FW + plt_pkg::GAIN_W;
   localparam logic [QW-1:0] FRAC_ONE = QW'(1) << plt_pkg::FRAC_BITS;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_LAST   = 9'b000000010,
      S_SCAN   = 9'b000000100,
      S_FETCH  = 9'b000001000,
      S_DIV    = 9'b000010000,
      S_INTERP = 9'b000100000,
      S_BLEND  = 9'b001000000,
      S_GAIN   = 9'b010000000,
      S_EMIT   = 9'b100000000
   } state_type;

   logic [WORD_W-1:0] mem [TABLE_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]  rd_addr, wr_addr;
   logic              wr_en;
   logic [TW-1:0]     rd_time;
   logic [FW-1:0]     rd_flow;

   state_type                    state_ff, state_in;
   logic [TW-1:0]                e_ff, e_in;
   logic [IDX_W-1:0]             h_ff, h_in;
   logic [TW-1:0]                t1_ff, t1_in;
   logic [FW-1:0]                f1_ff, f1_in;
   logic [FW-1:0]                f0_ff, f0_in;
   logic signed [FW:0]           diff_ff, diff_in;
   logic [TW-1:0]                div_ff, div_in;
   logic [TW-1:0]                rem_ff, rem_in;
   logic [QW-1:0]                bits_ff, bits_in;
   logic [QW-1:0]                quot_ff, quot_in;
   logic [plt_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   logic [FW-1:0]                flow_ff, flow_in;
   logic [plt_pkg::FLUX_W-1:0]   res_flux_ff, res_flux_in;
   logic                         res_win_ff, res_win_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [plt_pkg::FLUX_W-1:0]   rsp_flux_ff, rsp_flux_in;
   logic                         rsp_win_ff, rsp_win_in;

   logic [CMP_W-1:0]   count_wide, n_wide;
   logic [CNT_W-1:0]   n, n_m1, h_plus2;
   logic [IDX_W-1:0]   last_addr;
   logic [31:0]        wr_idx_wide;
   logic               advance;
   logic [TW:0]        shifted, shifted_sub;
   logic [TW-1:0]      span;
   logic [QW-1:0]      frac;
   logic signed [PROD_W-1:0] prod_mul, blend_sum;
   logic [GP_W-1:0]    gain_prod;

   // Entries in use, clamped to 2..TABLE_DEPTH.
   assign count_wide = CMP_W'(table_count);
   assign n_wide     = (count_wide < CMP_W'(2)) ? CMP_W'(2) :
                       (count_wide > CMP_W'(TABLE_DEPTH)) ? CMP_W'(TABLE_DEPTH) : count_wide;
   assign n          = n_wide[CNT_W-1:0];
   assign n_m1       = n - CNT_W'(1);
   assign last_addr  = n_m1[IDX_W-1:0];

   assign rd_time     = rd_data_ff[WORD_W-1:FW];
   assign rd_flow     = rd_data_ff[FW-1:0];
   assign wr_idx_wide = 32'(pop_cmd.idx);
   assign wr_addr     = wr_idx_wide[IDX_W-1:0];

   assign h_plus2  = CNT_W'(h_ff) + CNT_W'(2);
   assign advance  = (h_plus2 < n) && (rd_time < e_ff);

   assign span        = e_ff - rd_time;
   assign shifted     = {rem_ff, bits_ff[QW-1]};
   assign shifted_sub = shifted - {1'b0, div_ff};

   assign frac      = (quot_ff > FRAC_ONE) ? FRAC_ONE : quot_ff;
   assign prod_mul  = diff_ff * $signed({1'b0, frac});
   assign blend_sum = $signed({{(PROD_W - FW){1'b0}}, f0_ff})
                      + (prod_ff >>> plt_pkg::FRAC_BITS);
   assign gain_prod = GP_W'(flow_ff) * GP_W'(emission_gain);

   assign pop_ready         = state_ff == S_IDLE;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.flux_value = rsp_flux_ff;
   assign rsp_ch.in_window  = rsp_win_ff;

   always_comb begin
      state_in     = state_ff;
      e_in         = e_ff;
      h_in         = h_ff;
      t1_in        = t1_ff;
      f1_in        = f1_ff;
      f0_in        = f0_ff;
      diff_in      = diff_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      bits_in      = bits_ff;
      quot_in      = quot_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      flow_in      = flow_ff;
      res_flux_in  = res_flux_ff;
      res_win_in   = res_win_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_flux_in  = rsp_flux_ff;
      rsp_win_in   = rsp_win_ff;
      rd_addr      = '0;
      wr_en        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               res_flux_in = '0;
               res_win_in  = 1'b0;
               unique case (pop_cmd.op)
                  plt_pkg::OP_WRITE: begin
                     wr_en    = 1'b1;
                     state_in = S_EMIT;
                  end
                  plt_pkg::OP_QUERY: begin
                     e_in     = pop_cmd.tval;
                     rd_addr  = last_addr;
                     state_in = S_LAST;
                  end
                  default: begin
                     state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_LAST: begin
            if (e_ff > rd_time) begin
               state_in = S_EMIT;
            end else begin
               h_in     = '0;
               rd_addr  = IDX_W'(1);
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (advance) begin
               h_in    = h_ff + IDX_W'(1);
               rd_addr = h_plus2[IDX_W-1:0];
            end else begin
               t1_in    = rd_time;
               f1_in    = rd_flow;
               rd_addr  = h_ff;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            f0_in   = rd_flow;
            diff_in = $signed({1'b0, f1_ff}) - $signed({1'b0, rd_flow});
            if ((e_ff < rd_time) || (t1_ff <= rd_time)) begin
               flow_in  = rd_flow;
               state_in = S_GAIN;
            end else begin
               div_in   = t1_ff - rd_time;
               rem_in   = {1'b0, span[TW-1:1]};
               bits_in  = {span[0], {plt_pkg::FRAC_BITS{1'b0}}};
               quot_in  = '0;
               cnt_in   = plt_pkg::DIV_CNT_W'(plt_pkg::FRAC_BITS);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (shifted >= {1'b0, div_ff}) begin
               rem_in  = shifted_sub[TW-1:0];
               quot_in = {quot_ff[QW-2:0], 1'b1};
            end else begin
               rem_in  = shifted[TW-1:0];
               quot_in = {quot_ff[QW-2:0], 1'b0};
            end
            bits_in = bits_ff << 1;
            if (cnt_ff == '0) begin
               state_in = S_INTERP;
            end else begin
               cnt_in = cnt_ff - plt_pkg::DIV_CNT_W'(1);
            end
         end
         S_INTERP: begin
            prod_in  = prod_mul;
            state_in = S_BLEND;
         end
         S_BLEND: begin
            flow_in  = blend_sum[FW-1:0];
            state_in = S_GAIN;
         end
         S_GAIN: begin
            // The top bits of the product are exactly the flux width.
            res_flux_in = gain_prod[GP_W-1:plt_pkg::GAIN_FRAC];
            res_win_in  = 1'b1;
            state_in    = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_flux_in  = res_flux_ff;
               rsp_win_in   = res_win_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff        <= e_in;
      h_ff        <= h_in;
      t1_ff       <= t1_in;
      f1_ff       <= f1_in;
      f0_ff       <= f0_in;
      diff_ff     <= diff_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      bits_ff     <= bits_in;
      quot_ff     <= quot_in;
      cnt_ff      <= cnt_in;
      prod_ff     <= prod_in;
      flow_ff     <= flow_in;
      res_flux_ff <= res_flux_in;
      res_win_ff  <= res_win_in;
      rsp_flux_ff <= rsp_flux_in;
      rsp_win_ff  <= rsp_win_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {pop_cmd.tval, pop_cmd.flow};
      end
      rd_data_ff <= mem[rd_addr];
   end

   `PLT_ASSERT(a_frac_bounded, clock, reset, (state_ff == S_INTERP) |-> (quot_ff <= FRAC_ONE))
   `PLT_ASSERT(a_scan_in_table, clock, reset, (state_ff == S_SCAN) |-> ((CNT_W'(h_ff) + CNT_W'(1)) < n))
   `PLT_ASSERT(a_flow_between, clock, reset, (state_ff == S_GAIN) |-> ((flow_ff >= f0_ff && flow_ff <= f1_ff) || (flow_ff <= f0_ff && flow_ff >= f1_ff)))

endmodule

/* design/piecewise_linear_time_profile_core.sv */
// ----------------------------------------------------------------------------
// Piecewise-linear time profile core
// Breakpoint table load and linear interpolation of an emission flow over
// time, scaled by a gain.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake     payload
//   req_ch   in         valid/ready   req_type, entry_index, entry_time,
//                                     entry_flow, query_time
//   rsp_ch   out        valid/ready   flux_value, in_window
//   csr_ch   in         valid/ready   index, data (always ready)
//
// Sequence: a load or a query before onset goes straight to the response;
//   a query past the last breakpoint answers after reading that entry; an
//   interpolating query searches the segment over the single memory read
//   port, then runs the restoring divide of the fraction, the blend and the
//   gain.
// Reset: synchronous, clears the control state and loads the register
//   defaults; the table holds nothing meaningful until its entries are written.
// Stalls: a two-entry command queue keeps req_ch accepting while the back end
//   works, until the queue is full; the response register holds one response
//   while rsp_ch stalls, so the sequencer waits in S_EMIT only for a second one.
module piecewise_linear_time_profile_core #(
   parameter int TABLE_DEPTH = plt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   plt_req_if.sink     req_ch,
   plt_rsp_if.source   rsp_ch,
   plt_csr_if.sink     csr_ch
);

   // Configuration registers; the user must write them only while the core is idle (not enforced here).
   logic [plt_pkg::TIME_W-1:0]   onset_ff, onset_in;
   logic [plt_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [plt_pkg::GAIN_W-1:0]   gain_ff, gain_in;

   // Front-to-queue and queue-to-back command paths.
   logic              push_valid, push_ready;
   plt_pkg::cmd_type  push_cmd;
   logic              pop_valid, pop_ready;
   plt_pkg::cmd_type  pop_cmd;

   assign csr_ch.ready = 1'b1;

   // Decode the register write; drop writes to unknown indexes.
   always_comb begin
      onset_in = onset_ff;
      count_in = count_ff;
      gain_in  = gain_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            plt_pkg::CSR_ONSET: onset_in = csr_ch.data[plt_pkg::TIME_W-1:0];
            plt_pkg::CSR_COUNT: count_in = csr_ch.data[plt_pkg::COUNT_W-1:0];
            plt_pkg::CSR_GAIN:  gain_in  = csr_ch.data[plt_pkg::GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         onset_ff <= plt_pkg::ONSET_RESET;
         count_ff <= plt_pkg::COUNT_RESET;
         gain_ff  <= plt_pkg::GAIN_RESET;
      end else begin
         onset_ff <= onset_in;
         count_ff <= count_in;
         gain_ff  <= gain_in;
      end
   end

   // Classify requests, form elapsed time against onset.
   plt_front #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_front (
      .req_ch     (req_ch),
      .onset_time (onset_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   // Hold classified commands so either side can stall on its own.
   plt_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // Write the table, search, divide, blend, scale, and respond.
   plt_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_cmd       (pop_cmd),
      .table_count   (count_ff),
      .emission_gain (gain_ff),
      .rsp_ch        (rsp_ch)
   );

endmodule
